[design/packed_yuv_to_rgb_converter_top_defines.svh]
// assertion macros shared by the design files
`ifndef PACKED_YUV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define PACKED_YUV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication
`define PYR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PYR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pyr_pkg.sv]
package pyr_pkg;

  typedef enum logic [1:0] {
    FmtYuyv = 2'd0,
    FmtUyvy = 2'd1,
    FmtY411 = 2'd2
  } fmt_e;

  typedef enum logic [2:0] {
    SlotY0 = 3'd0,
    SlotY1 = 3'd1,
    SlotY2 = 3'd2,
    SlotY3 = 3'd3,
    SlotU  = 3'd4,
    SlotV  = 3'd5
  } slot_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_last;
  } byte_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       group_end;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic [3:0][7:0] luma;
    logic [7:0]      u;
    logic [7:0]      v;
    logic            quad;
    logic            frame_last;
  } grp_t;

  typedef logic signed [8:0] off_t;
  typedef off_t [255:0] off_tab_t;

  localparam int CoefRv    = 14075;
  localparam int CoefGu    = 3455;
  localparam int CoefGv    = 7169;
  localparam int CoefBu    = 17790;
  localparam int CoefScale = 10000;

  // rounded chroma offset per byte value, half away from zero
  function automatic off_tab_t build_tab(int coef);
    off_tab_t t;
    int d;
    int p;
    int r;
    for (int i = 0; i < 256; i++) begin
      d = i - 128;
      p = coef * d;
      if (p >= 0) begin
        r = (p + CoefScale / 2) / CoefScale;
      end else begin
        r = -((-p + CoefScale / 2) / CoefScale);
      end
      t[i] = off_t'(r);
    end
    return t;
  endfunction

  localparam off_tab_t RvTab = build_tab(CoefRv);
  localparam off_tab_t GuTab = build_tab(CoefGu);
  localparam off_tab_t GvTab = build_tab(CoefGv);
  localparam off_tab_t BuTab = build_tab(CoefBu);

  function automatic slot_e slot_kind(logic [1:0] fmt, logic [2:0] pos);
    slot_e k;
    k = SlotY0;
    if (fmt == FmtY411) begin
      unique case (pos)
        3'd0: k = SlotU;
        3'd1: k = SlotY0;
        3'd2: k = SlotY1;
        3'd3: k = SlotV;
        3'd4: k = SlotY2;
        3'd5: k = SlotY3;
        default: k = SlotU;
      endcase
    end else if (fmt == FmtUyvy) begin
      unique case (pos[1:0])
        2'd0: k = SlotU;
        2'd1: k = SlotY0;
        2'd2: k = SlotV;
        2'd3: k = SlotY1;
        default: k = SlotU;
      endcase
    end else begin
      unique case (pos[1:0])
        2'd0: k = SlotY0;
        2'd1: k = SlotU;
        2'd2: k = SlotY1;
        2'd3: k = SlotV;
        default: k = SlotY0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [7:0] sat8(logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[design/pyr_front.sv]
module pyr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pyr_pkg::byte_t in_data_i,
  output logic          push_o,
  output pyr_pkg::grp_t push_data_o,
  input  logic          full_i
);
  import pyr_pkg::*;

  logic [1:0]      fmt_q;
  logic [2:0]      pos_q;
  logic [2:0]      pos_eff;
  logic [2:0]      last_pos;
  logic            quad;
  logic            completes;
  logic            accept;
  slot_e           kind;
  logic [3:0][7:0] luma_q, luma_d;
  logic [7:0]      u_q, u_d;
  logic [7:0]      v_q, v_d;

  assign quad      = (fmt_q == FmtY411);
  assign last_pos  = quad ? 3'd5 : 3'd3;
  assign pos_eff   = (pos_q > last_pos) ? 3'd0 : pos_q;
  assign completes = (pos_eff == last_pos);
  assign kind      = slot_kind(fmt_q, pos_eff);

  assign in_ready_o = !(full_i && completes);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && completes;

  always_comb begin
    luma_d = luma_q;
    u_d    = u_q;
    v_d    = v_q;
    unique case (kind)
      SlotU:   u_d = in_data_i.stream_byte;
      SlotV:   v_d = in_data_i.stream_byte;
      default: luma_d[kind[1:0]] = in_data_i.stream_byte;
    endcase
  end

  assign push_data_o.luma       = luma_d;
  assign push_data_o.u          = u_d;
  assign push_data_o.v          = v_d;
  assign push_data_o.quad       = quad;
  assign push_data_o.frame_last = in_data_i.frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtYuyv;
      pos_q <= 3'd0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_data_i;
      pos_q <= 3'd0;
    end else if (accept) begin
      pos_q <= (completes || in_data_i.frame_last) ? 3'd0 : pos_eff + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      luma_q <= luma_d;
      u_q    <= u_d;
      v_q    <= v_d;
    end
  end

endmodule

[design/pyr_fifo.sv]
`include "packed_yuv_to_rgb_converter_top_defines.svh"

module pyr_fifo #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pyr_pkg::grp_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pyr_pkg::grp_t pop_data_o
);
  import pyr_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + IdxW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + IdxW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `PYR_ASSERT_NOW(a_no_overflow, push_i, !full_o, "group pushed into full queue")
  `PYR_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "group popped from empty queue")

endmodule

[design/pyr_back.sv]
`include "packed_yuv_to_rgb_converter_top_defines.svh"

module pyr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pyr_pkg::grp_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pyr_pkg::pix_t out_data_o
);
  import pyr_pkg::*;

  logic              grp_valid_q;
  grp_t              grp_q;
  logic [1:0]        pix_q;
  off_t              roff_q, boff_q;
  logic signed [9:0] goff_q;
  logic              out_valid_q;
  pix_t              out_q;
  logic              emit;
  logic              last_pix;
  logic              load;
  logic signed [9:0] y_s;
  pix_t              pix;

  assign emit     = grp_valid_q && (!out_valid_q || out_ready_i);
  assign last_pix = grp_q.quad ? (pix_q == 2'd3) : (pix_q == 2'd1);
  assign load     = q_valid_i && (!grp_valid_q || (emit && last_pix));
  assign q_pop_o  = load;

  assign y_s             = {2'b00, grp_q.luma[pix_q]};
  assign pix.red         = sat8(y_s + 10'(roff_q));
  assign pix.green       = sat8(y_s - goff_q);
  assign pix.blue        = sat8(y_s + 10'(boff_q));
  assign pix.group_end   = last_pix;
  assign pix.frame_end   = last_pix && grp_q.frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      pix_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        grp_valid_q <= 1'b1;
        pix_q       <= 2'd0;
      end else if (emit) begin
        if (last_pix) begin
          grp_valid_q <= 1'b0;
        end
        pix_q <= pix_q + 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q  <= q_data_i;
      roff_q <= RvTab[q_data_i.v];
      boff_q <= BuTab[q_data_i.u];
      goff_q <= 10'(GuTab[q_data_i.u]) + 10'(GvTab[q_data_i.v]);
    end
    if (emit) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PYR_ASSERT_NEXT(a_load_restarts, load, pix_q == 2'd0, "pixel index not cleared on load")
  `PYR_ASSERT_NOW(a_pair_index, grp_valid_q && !grp_q.quad, pix_q[1] == 1'b0,
                  "pixel index beyond a two-pixel group")
  `PYR_ASSERT_NOW(a_frame_on_group, out_valid_o && out_data_o.frame_end,
                  out_data_o.group_end, "frame end off the last pixel of a group")

endmodule

[design/packed_yuv_to_rgb_converter_top.sv]
// channel | dir | handshake                | payload
// cfg     | in  | cfg_we_i                 | cfg_data_i (packing format)
// in      | in  | in_valid_i / in_ready_o  | in_data_i (stream byte, frame last)
// out     | out | out_valid_o / out_ready_i| out_data_o (rgb, group end, frame end)
// one byte per cycle in while in_ready_o is high, one pixel per cycle out while
// out_ready_i is high; a group of 4 bytes (6 for Y411) yields 2 pixels (4) through
// the queue, group and output registers; the pixel emitter sets the output rate
// reset clears the format to YUYV and the group position; no clearing pass
// bytes keep flowing while the group queue has room; a full queue stalls
// only the byte that completes a group
module packed_yuv_to_rgb_converter_top #(
  parameter int QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pyr_pkg::byte_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pyr_pkg::pix_t  out_data_o
);
  import pyr_pkg::*;

  logic push;
  grp_t push_data;
  logic full;
  logic pop;
  logic empty;
  grp_t pop_data;

  pyr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  pyr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  pyr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
